[hw/rtl/fgd_pkg.sv]
// Shared types and constants of the font glyph decoder.
// Used by fgd_front, fgd_queue, fgd_back and the top level; no dependencies.
package fgd_pkg;

	localparam logic [31:0] MAGIC_WORD = 32'h464F_4E54;
	localparam int MIN_SIZE   = 32;
	localparam int GLYPH_BASE = 36;
	localparam int NARROW_W   = 6;
	localparam int WIDE_W     = 12;
	localparam int GLYPH_H    = 12;

	localparam int P_MAGIC0 = 3;
	localparam int P_INDEX  = 7;
	localparam int P_MAGIC1 = 11;
	localparam int P_EXTRA  = 15;
	localparam int P_FORMAT = 19;
	localparam int P_COUNT  = 21;
	localparam int P_WIDTH  = 23;
	localparam int P_START  = 24;
	localparam int P_HEIGHT = 25;

	localparam int GS_W   = 22;
	localparam int QDEPTH = 4;

	localparam logic RESULT_PIXEL  = 1'b0;
	localparam logic RESULT_STATUS = 1'b1;

	typedef enum logic [1:0] {
		REG_RESOURCE_NUMBER,
		REG_GLYPH_NUMBER,
		REG_RESOURCE_LENGTH,
		REG_PIXEL_ROOM
	} cfg_reg_t;

	typedef struct packed {
		logic        header_valid;
		logic        glyph_ok;
		logic [15:0] glyph_count;
		logic [15:0] glyph_width;
		logic [15:0] glyph_height;
		logic [31:0] format_value;
		logic [31:0] extra_header_word;
	} status_t;

	typedef struct packed {
		logic        pix;
		logic [7:0]  data;
		logic [3:0]  col;
		logic [3:0]  row;
		logic [3:0]  width;
		logic        fin;
		status_t     stat;
	} task_t;

	typedef struct packed {
		logic        result_kind;
		logic [1:0]  pixel_value;
		logic [3:0]  pixel_column;
		logic [3:0]  pixel_row;
		status_t     stat;
		logic        last_result;
	} result_t;

endpackage

[hw/rtl/fgd_front.sv]
// Front end: configuration registers, header parsing and glyph decision.
// Emits one task word per glyph byte or final byte. Depends on fgd_pkg.
module fgd_front #(
	parameter int MAX_RESOURCE_BYTES = 1048576
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic                 final_byte,
	output logic                 task_push,
	output fgd_pkg::task_t       task_word
);

	localparam int POS_W = $clog2(MAX_RESOURCE_BYTES + 1);
	localparam int LW    = (POS_W > 21) ? POS_W : 21;
	localparam int CW    = ((LW > fgd_pkg::GS_W + 1) ? LW : fgd_pkg::GS_W + 1) + 1;

	logic [31:0] resource_number_q;
	logic [15:0] glyph_number_q;
	logic [20:0] resource_length_q;
	logic [9:0]  pixel_room_q;

	logic [POS_W-1:0]        pos_q, pos_n;
	logic                    ok_q, ok_n;
	logic [31:0]             shift_q, shift_n;
	logic [31:0]             extra_q, extra_n;
	logic [31:0]             fmt_q, fmt_n;
	logic [15:0]             cnt_q, cnt_n;
	logic [15:0]             wid_q, wid_n;
	logic [15:0]             hgt_q, hgt_n;
	logic [fgd_pkg::GS_W-1:0] gstart_q, gstart_n;
	logic                    dec_q, dec_n;
	logic [3:0]              row_q, row_n;
	logic [3:0]              col_q, col_n;

	logic [LW-1:0]           len_ext, eff_len;
	logic                    wide;
	logic [fgd_pkg::GS_W-1:0] gbytes;
	logic [CW-1:0]           gend;
	logic                    shape_n, pix, hdr;
	logic [15:0]             col_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resource_number_q <= '0;
			glyph_number_q    <= '0;
			resource_length_q <= '0;
			pixel_room_q      <= '0;
		end else if (cfg_write) begin
			unique case (fgd_pkg::cfg_reg_t'(cfg_index))
				fgd_pkg::REG_RESOURCE_NUMBER: resource_number_q <= cfg_data;
				fgd_pkg::REG_GLYPH_NUMBER:    glyph_number_q    <= cfg_data[15:0];
				fgd_pkg::REG_RESOURCE_LENGTH: resource_length_q <= cfg_data[20:0];
				fgd_pkg::REG_PIXEL_ROOM:      pixel_room_q      <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign len_ext = LW'(resource_length_q);
	assign eff_len = (len_ext > LW'(MAX_RESOURCE_BYTES)) ? LW'(MAX_RESOURCE_BYTES) : len_ext;
	assign wide    = (wid_q == 16'(fgd_pkg::WIDE_W));
	assign gbytes  = wide ? fgd_pkg::GS_W'(36) : fgd_pkg::GS_W'(24);
	assign gend    = CW'(gstart_q) + CW'(gbytes);

	always_comb begin
		pos_n    = pos_q;
		ok_n     = ok_q;
		shift_n  = {shift_q[23:0], data_byte};
		extra_n  = extra_q;
		fmt_n    = fmt_q;
		cnt_n    = cnt_q;
		wid_n    = wid_q;
		hgt_n    = hgt_q;
		gstart_n = gstart_q;
		dec_n    = dec_q;
		row_n    = row_q;
		col_n    = col_q;
		shape_n  = 1'b0;
		pix      = 1'b0;
		col_next = 16'(col_q) + 16'd4;
		case (pos_q)
			POS_W'(fgd_pkg::P_MAGIC0),
			POS_W'(fgd_pkg::P_MAGIC1): begin
				if (shift_n != fgd_pkg::MAGIC_WORD)
					ok_n = 1'b0;
			end
			POS_W'(fgd_pkg::P_INDEX): begin
				if (shift_n != resource_number_q)
					ok_n = 1'b0;
			end
			POS_W'(fgd_pkg::P_EXTRA):  extra_n = shift_n;
			POS_W'(fgd_pkg::P_FORMAT): fmt_n   = shift_n;
			POS_W'(fgd_pkg::P_COUNT):  cnt_n   = shift_n[15:0];
			POS_W'(fgd_pkg::P_WIDTH):  wid_n   = shift_n[15:0];
			POS_W'(fgd_pkg::P_HEIGHT): begin
				hgt_n   = shift_n[15:0];
				shape_n = (cnt_q != 16'd0) && (hgt_n == 16'(fgd_pkg::GLYPH_H)) &&
					(wide || wid_q == 16'(fgd_pkg::NARROW_W));
				row_n   = '0;
				col_n   = '0;
				dec_n   = ok_q && (eff_len >= LW'(fgd_pkg::MIN_SIZE)) && shape_n &&
					(glyph_number_q < cnt_q) &&
					((wide ? 10'd144 : 10'd72) <= pixel_room_q) &&
					(gend <= CW'(eff_len));
			end
			default: begin
				pix = dec_q && (CW'(pos_q) >= CW'(gstart_q)) && (16'(row_q) < hgt_q);
				if (pix) begin
					if (col_next >= wid_q) begin
						col_n = '0;
						row_n = row_q + 4'd1;
					end else begin
						col_n = col_next[3:0];
					end
				end
			end
		endcase
		// glyph offset is ready one byte ahead of the decision
		if (pos_q == POS_W'(fgd_pkg::P_START))
			gstart_n = fgd_pkg::GS_W'(fgd_pkg::GLYPH_BASE) +
				(wide ? ({6'd0, glyph_number_q} << 5) + ({6'd0, glyph_number_q} << 2)
				      : ({6'd0, glyph_number_q} << 4) + ({6'd0, glyph_number_q} << 3));
		if (pos_q < POS_W'(MAX_RESOURCE_BYTES))
			pos_n = pos_q + POS_W'(1);
	end

	always_comb begin
		hdr = (pos_q >= POS_W'(fgd_pkg::P_HEIGHT)) && ok_n &&
			(eff_len >= LW'(fgd_pkg::MIN_SIZE));
		task_word.pix   = pix;
		task_word.data  = data_byte;
		task_word.col   = col_q;
		task_word.row   = row_q;
		task_word.width = wid_q[3:0];
		task_word.fin   = final_byte;
		task_word.stat.header_valid = hdr && (cnt_n != 16'd0) &&
			(hgt_n == 16'(fgd_pkg::GLYPH_H)) &&
			(wid_n == 16'(fgd_pkg::WIDE_W) || wid_n == 16'(fgd_pkg::NARROW_W));
		task_word.stat.glyph_ok          = dec_n && (16'(row_n) >= hgt_n);
		task_word.stat.glyph_count       = hdr ? cnt_n : '0;
		task_word.stat.glyph_width       = hdr ? wid_n : '0;
		task_word.stat.glyph_height      = hdr ? hgt_n : '0;
		task_word.stat.format_value      = hdr ? fmt_n : '0;
		task_word.stat.extra_header_word = hdr ? extra_n : '0;
		task_push = accept && (pix || final_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			ok_q     <= 1'b1;
			shift_q  <= '0;
			extra_q  <= '0;
			fmt_q    <= '0;
			cnt_q    <= '0;
			wid_q    <= '0;
			hgt_q    <= '0;
			gstart_q <= '0;
			dec_q    <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
		end else if (accept) begin
			if (final_byte) begin
				pos_q    <= '0;
				ok_q     <= 1'b1;
				shift_q  <= '0;
				extra_q  <= '0;
				fmt_q    <= '0;
				cnt_q    <= '0;
				wid_q    <= '0;
				hgt_q    <= '0;
				gstart_q <= '0;
				dec_q    <= 1'b0;
				row_q    <= '0;
				col_q    <= '0;
			end else begin
				pos_q    <= pos_n;
				ok_q     <= ok_n;
				shift_q  <= shift_n;
				extra_q  <= extra_n;
				fmt_q    <= fmt_n;
				cnt_q    <= cnt_n;
				wid_q    <= wid_n;
				hgt_q    <= hgt_n;
				gstart_q <= gstart_n;
				dec_q    <= dec_n;
				row_q    <= row_n;
				col_q    <= col_n;
			end
		end
	end

endmodule

[hw/rtl/fgd_queue.sv]
// Task queue between the front end and the pixel back end.
// Holds fgd_pkg::task_t words in first-in first-out order. Depends on fgd_pkg.
module fgd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fgd_pkg::task_t  push_word,
	input  logic            pop,
	output fgd_pkg::task_t  head_word,
	output logic            full,
	output logic            empty
);

	localparam int PW = $clog2(fgd_pkg::QDEPTH);
	localparam int CNW = $clog2(fgd_pkg::QDEPTH + 1);

	fgd_pkg::task_t    entry_q [fgd_pkg::QDEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNW-1:0]    count_q;
	logic              do_push, do_pop;

	assign full      = (count_q == CNW'(fgd_pkg::QDEPTH));
	assign empty     = (count_q == '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign head_word = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNW'(1);
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("task pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("task popped from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNW'(fgd_pkg::QDEPTH)) else $error("queue count out of range");

endmodule

[hw/rtl/fgd_back.sv]
// Back end: unpacks each task word into pixel results and, for a final word, a status result.
// Drives the registered result word. Depends on fgd_pkg.
module fgd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  fgd_pkg::task_t   head_word,
	output logic             head_pop,
	input  logic             pop,
	output logic             empty,
	output fgd_pkg::result_t result
);

	logic [2:0]        step_q;
	logic              out_valid_q;
	fgd_pkg::result_t  result_q, result_d;
	logic              in_pix, pix_hit, stat_hit, done, advance, load;
	logic [3:0]        xpos;
	logic [1:0]        bits;

	assign in_pix   = head_word.pix && (step_q < 3'd4);
	assign xpos     = head_word.col + 4'(step_q[1:0]);
	assign pix_hit  = in_pix && (xpos < head_word.width);
	assign stat_hit = !in_pix && head_word.fin;
	assign done     = in_pix ? (step_q[1:0] == 2'd3 && !head_word.fin) : 1'b1;
	assign advance  = head_valid && (!out_valid_q || pop);
	assign load     = advance && (pix_hit || stat_hit);
	assign head_pop = advance && done;

	always_comb begin
		unique case (step_q[1:0])
			2'd0:    bits = head_word.data[7:6];
			2'd1:    bits = head_word.data[5:4];
			2'd2:    bits = head_word.data[3:2];
			default: bits = head_word.data[1:0];
		endcase
		result_d = '0;
		if (in_pix) begin
			result_d.result_kind  = fgd_pkg::RESULT_PIXEL;
			result_d.pixel_value  = ~bits;
			result_d.pixel_column = xpos;
			result_d.pixel_row    = head_word.row;
		end else begin
			result_d.result_kind = fgd_pkg::RESULT_STATUS;
			result_d.stat        = head_word.stat;
			result_d.last_result = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			result_q <= result_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				step_q <= head_pop ? 3'd0 : step_q + 3'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	assign empty  = !out_valid_q;
	assign result = result_q;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= 3'd4) else $error("unpack step out of range");
	a_status_after_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == 3'd4) |-> (head_valid && head_word.fin))
		else $error("status step without a final task");
	a_pixel_column: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.result_kind == fgd_pkg::RESULT_PIXEL) |->
		(result_q.pixel_column < 4'd12)) else $error("pixel column beyond glyph");

endmodule

[hw/rtl/font_resource_glyph_decoder.sv]
// Top level of the font glyph decoder: front end, task queue, back end.
// Depends on fgd_pkg, fgd_front, fgd_queue and fgd_back.
//
//   channel   handshake        payload
//   input     push / full      data_byte, final_byte
//   result    empty / pop      result_kind .. last_result
//   config    cfg_write        cfg_index, cfg_data
//
// A byte is taken every cycle while the task queue has room.
// A glyph byte occupies the back end for four unpack steps (one per pixel slot); a final byte
// adds one step for its status word. The back end unpack step sets the sustained rate.
// Reset clears all stream state; there is no clearing pass. Either side may stall freely.
module font_resource_glyph_decoder #(
	parameter int MAX_RESOURCE_BYTES = 1048576
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        empty,
	input  logic        pop,
	output logic        result_kind,
	output logic [1:0]  pixel_value,
	output logic [3:0]  pixel_column,
	output logic [3:0]  pixel_row,
	output logic        header_valid,
	output logic        glyph_ok,
	output logic [15:0] glyph_count,
	output logic [15:0] glyph_width,
	output logic [15:0] glyph_height,
	output logic [31:0] format_value,
	output logic [31:0] extra_header_word,
	output logic        last_result
);

	fgd_pkg::task_t   task_word, head_word;
	fgd_pkg::result_t result;
	logic             task_push, q_full, q_empty, head_pop, accept;

	assign full   = q_full;
	assign accept = push && !q_full;

	fgd_front #(
		.MAX_RESOURCE_BYTES(MAX_RESOURCE_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.task_push  (task_push),
		.task_word  (task_word)
	);

	fgd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (task_push),
		.push_word (task_word),
		.pop       (head_pop),
		.head_word (head_word),
		.full      (q_full),
		.empty     (q_empty)
	);

	fgd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head_word  (head_word),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

	assign result_kind       = result.result_kind;
	assign pixel_value       = result.pixel_value;
	assign pixel_column      = result.pixel_column;
	assign pixel_row         = result.pixel_row;
	assign header_valid      = result.stat.header_valid;
	assign glyph_ok          = result.stat.glyph_ok;
	assign glyph_count       = result.stat.glyph_count;
	assign glyph_width       = result.stat.glyph_width;
	assign glyph_height      = result.stat.glyph_height;
	assign format_value      = result.stat.format_value;
	assign extra_header_word = result.stat.extra_header_word;
	assign last_result       = result.last_result;

endmodule

[tb/font_resource_glyph_decoder_test.sv]
// Self-checking testbench for font_resource_glyph_decoder: header, bounds and glyph unpacking.
// Streams whole font resources through the push/full side and predicts every word on the pop side.
// Depends on fgd_pkg and the font_resource_glyph_decoder RTL.
`timescale 1ns / 100ps

module font_resource_glyph_decoder_test;

	localparam int MAX_BYTES   = 1048576;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE      = 24;
	localparam int PHASE_BYTES = 62;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} font_byte_t;

	typedef enum {STREAM_CLEAN, STREAM_BROKEN, STREAM_NOISE} stream_form_t;
	typedef enum {FLAW_COUNT, FLAW_WIDTH, FLAW_HEIGHT, FLAW_SIGNATURE} flaw_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = '0;
	logic        final_byte = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic        result_kind;
	logic [1:0]  pixel_value;
	logic [3:0]  pixel_column;
	logic [3:0]  pixel_row;
	logic        header_valid;
	logic        glyph_ok;
	logic [15:0] glyph_count;
	logic [15:0] glyph_width;
	logic [15:0] glyph_height;
	logic [31:0] format_value;
	logic [31:0] extra_header_word;
	logic        last_result;

	font_byte_t         bytes_to_send[$];
	fgd_pkg::result_t   words_due[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned mismatches = 0;
	int unsigned words_checked = 0;
	int unsigned pixel_words = 0;
	int unsigned status_words = 0;
	int unsigned glyphs_done = 0;
	int unsigned streams_sent = 0;
	int unsigned bytes_sent = 0;
	int unsigned stall_cycles = 0;

	// register copies
	logic [31:0] set_resource = '0;
	logic [15:0] set_glyph = '0;
	logic [20:0] set_length = '0;
	logic [9:0]  set_room = '0;

	// stream state of the decoder
	int unsigned at_byte = 0;
	bit          header_intact = 1'b1;
	logic [31:0] recent_bytes = '0;
	logic [31:0] word12 = '0;
	logic [31:0] format_seen = '0;
	logic [15:0] font_count = '0;
	logic [15:0] font_width = '0;
	logic [15:0] font_height = '0;
	int unsigned glyph_base_at = 0;
	bit          unpacking = 1'b0;
	int unsigned row_at = 0;
	int unsigned col_at = 0;

	font_resource_glyph_decoder #(.MAX_RESOURCE_BYTES(MAX_BYTES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.final_byte(final_byte),
		.empty(empty),
		.pop(pop),
		.result_kind(result_kind),
		.pixel_value(pixel_value),
		.pixel_column(pixel_column),
		.pixel_row(pixel_row),
		.header_valid(header_valid),
		.glyph_ok(glyph_ok),
		.glyph_count(glyph_count),
		.glyph_width(glyph_width),
		.glyph_height(glyph_height),
		.format_value(format_value),
		.extra_header_word(extra_header_word),
		.last_result(last_result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int unsigned usable_length();
		return (set_length > MAX_BYTES) ? MAX_BYTES : set_length;
	endfunction

	function automatic bit shape_fits();
		return font_count != 0 &&
			(font_width == fgd_pkg::NARROW_W || font_width == fgd_pkg::WIDE_W) &&
			font_height == fgd_pkg::GLYPH_H;
	endfunction

	function automatic string describe(fgd_pkg::result_t r);
		return $sformatf({"kind %0d pix %0d col %0d row %0d hv %0d ok %0d count %0d ",
			"width %0d height %0d fmt %h w12 %h last %0d"},
			r.result_kind, r.pixel_value, r.pixel_column, r.pixel_row,
			r.stat.header_valid, r.stat.glyph_ok, r.stat.glyph_count, r.stat.glyph_width,
			r.stat.glyph_height, r.stat.format_value, r.stat.extra_header_word, r.last_result);
	endfunction

	task automatic predict_font_byte(input logic [7:0] b, input logic fin);
		int unsigned p, x, v, k, bpl, gbytes, off, len;
		fgd_pkg::result_t w;
		bit hdr;
		p = at_byte;
		recent_bytes = {recent_bytes[23:0], b};
		case (p)
			fgd_pkg::P_MAGIC0, fgd_pkg::P_MAGIC1: begin
				if (recent_bytes != fgd_pkg::MAGIC_WORD)
					header_intact = 1'b0;
			end
			fgd_pkg::P_INDEX: begin
				if (recent_bytes != set_resource)
					header_intact = 1'b0;
			end
			fgd_pkg::P_EXTRA: word12 = recent_bytes;
			fgd_pkg::P_FORMAT: format_seen = recent_bytes;
			fgd_pkg::P_COUNT: font_count = recent_bytes[15:0];
			fgd_pkg::P_WIDTH: font_width = recent_bytes[15:0];
			fgd_pkg::P_HEIGHT: begin
				font_height = recent_bytes[15:0];
				unpacking = 1'b0;
				row_at = 0;
				col_at = 0;
				len = usable_length();
				bpl = (int'(font_width) + 3) / 4;
				gbytes = bpl * font_height;
				off = fgd_pkg::GLYPH_BASE + set_glyph * gbytes;
				if (header_intact && len >= fgd_pkg::MIN_SIZE && shape_fits() &&
						set_glyph < font_count &&
						int'(font_width) * int'(font_height) <= set_room &&
						off <= len && gbytes <= len - off) begin
					glyph_base_at = off;
					unpacking = 1'b1;
				end
			end
			default: begin
				if (unpacking && p >= glyph_base_at && row_at < font_height) begin
					for (k = 0; k < 4; k++) begin
						x = col_at + k;
						if (x < font_width) begin
							v = 3 - ((b >> (6 - 2 * k)) & 3);
							w = '0;
							w.result_kind = fgd_pkg::RESULT_PIXEL;
							w.pixel_value = v[1:0];
							w.pixel_column = x[3:0];
							w.pixel_row = row_at[3:0];
							words_due.push_back(w);
						end
					end
					col_at += 4;
					if (col_at >= font_width) begin
						col_at = 0;
						row_at++;
					end
				end
			end
		endcase
		if (p < MAX_BYTES)
			at_byte = p + 1;
		if (fin) begin
			hdr = p >= fgd_pkg::P_HEIGHT && header_intact &&
				usable_length() >= fgd_pkg::MIN_SIZE;
			w = '0;
			w.result_kind = fgd_pkg::RESULT_STATUS;
			w.stat.header_valid = hdr && shape_fits();
			w.stat.glyph_ok = unpacking && row_at >= font_height;
			if (hdr) begin
				w.stat.glyph_count = font_count;
				w.stat.glyph_width = font_width;
				w.stat.glyph_height = font_height;
				w.stat.format_value = format_seen;
				w.stat.extra_header_word = word12;
			end
			w.last_result = 1'b1;
			words_due.push_back(w);
			at_byte = 0;
			header_intact = 1'b1;
			recent_bytes = '0;
			word12 = '0;
			format_seen = '0;
			font_count = '0;
			font_width = '0;
			font_height = '0;
			glyph_base_at = 0;
			unpacking = 1'b0;
			row_at = 0;
			col_at = 0;
		end
	endtask

	task automatic set_config(input logic [31:0] resource, input logic [15:0] glyph,
			input logic [20:0] length, input logic [9:0] room);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= fgd_pkg::REG_RESOURCE_NUMBER;
		cfg_data <= resource;
		set_resource = resource;
		@(negedge clk);
		cfg_index <= fgd_pkg::REG_GLYPH_NUMBER;
		cfg_data <= {16'd0, glyph};
		set_glyph = glyph;
		@(negedge clk);
		cfg_index <= fgd_pkg::REG_RESOURCE_LENGTH;
		cfg_data <= {11'd0, length};
		set_length = length;
		@(negedge clk);
		cfg_index <= fgd_pkg::REG_PIXEL_ROOM;
		cfg_data <= {22'd0, room};
		set_room = room;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic queue_stream(input stream_form_t form, input int unsigned cut,
			output int unsigned sent);
		logic [7:0] s[$];
		logic [15:0] count, wide, tall;
		int unsigned len, gbytes, i;
		flaw_t flaw;
		wide = $urandom_range(1) ? 16'(fgd_pkg::NARROW_W) : 16'(fgd_pkg::WIDE_W);
		tall = 16'(fgd_pkg::GLYPH_H);
		count = ($urandom_range(7) == 0) ? 16'hFFFF : set_glyph + 16'($urandom_range(1, 4));
		flaw = flaw_t'($urandom_range(3));
		if (form == STREAM_BROKEN) begin
			case (flaw)
				FLAW_COUNT: count = '0;
				FLAW_WIDTH: wide = 16'($urandom);
				FLAW_HEIGHT: tall = 16'($urandom);
				default: ;
			endcase
		end
		for (i = 0; i < 4; i++)
			s.push_back(fgd_pkg::MAGIC_WORD[31 - 8 * i -: 8]);
		for (i = 0; i < 4; i++)
			s.push_back(set_resource[31 - 8 * i -: 8]);
		for (i = 0; i < 4; i++)
			s.push_back(fgd_pkg::MAGIC_WORD[31 - 8 * i -: 8]);
		for (i = 0; i < 8; i++)
			s.push_back(8'($urandom));
		s.push_back(count[15:8]);
		s.push_back(count[7:0]);
		s.push_back(wide[15:8]);
		s.push_back(wide[7:0]);
		s.push_back(tall[15:8]);
		s.push_back(tall[7:0]);
		if (set_glyph < 4 && (wide == fgd_pkg::NARROW_W || wide == fgd_pkg::WIDE_W)) begin
			gbytes = ((int'(wide) + 3) / 4) * fgd_pkg::GLYPH_H;
			len = fgd_pkg::GLYPH_BASE + (set_glyph + 1) * gbytes;
		end else begin
			len = $urandom_range(fgd_pkg::P_HEIGHT + 1, 40);
		end
		case ($urandom_range(9))
			0, 1: len = $urandom_range(1, len - 1);
			2: len += $urandom_range(1, 6);
			default: ;
		endcase
		if (form == STREAM_BROKEN && flaw == FLAW_SIGNATURE) begin
			i = $urandom_range(11);
			s[i] = s[i] ^ 8'($urandom_range(1, 255));
		end
		if (form == STREAM_NOISE) begin
			s.delete();
			len = $urandom_range(1, 40);
		end
		if (cut != 0)
			len = cut;
		while (s.size() < len)
			s.push_back(8'($urandom));
		for (i = 0; i < len; i++)
			bytes_to_send.push_back('{value: s[i], last: (i == len - 1)});
		streams_sent++;
		sent = len;
	endtask

	always @(negedge clk) begin
		if (arst_n && bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			push <= 1'b1;
			data_byte <= bytes_to_send[0].value;
			final_byte <= bytes_to_send[0].last;
		end else begin
			push <= 1'b0;
		end
		pop <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : monitor
		fgd_pkg::result_t got, want;
		string bad;
		if (arst_n && push && !full) begin
			predict_font_byte(data_byte, final_byte);
			void'(bytes_to_send.pop_front());
			bytes_sent++;
		end
		if (arst_n && pop && !empty) begin
			got.result_kind = result_kind;
			got.pixel_value = pixel_value;
			got.pixel_column = pixel_column;
			got.pixel_row = pixel_row;
			got.stat.header_valid = header_valid;
			got.stat.glyph_ok = glyph_ok;
			got.stat.glyph_count = glyph_count;
			got.stat.glyph_width = glyph_width;
			got.stat.glyph_height = glyph_height;
			got.stat.format_value = format_value;
			got.stat.extra_header_word = extra_header_word;
			got.last_result = last_result;
			if (words_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("word %0d with nothing due: %s", words_checked, describe(got));
			end else begin
				want = words_due.pop_front();
				bad = "";
				if (got.result_kind !== want.result_kind) bad = {bad, " result_kind"};
				if (got.pixel_value !== want.pixel_value) bad = {bad, " pixel_value"};
				if (got.pixel_column !== want.pixel_column) bad = {bad, " pixel_column"};
				if (got.pixel_row !== want.pixel_row) bad = {bad, " pixel_row"};
				if (got.stat.header_valid !== want.stat.header_valid)
					bad = {bad, " header_valid"};
				if (got.stat.glyph_ok !== want.stat.glyph_ok) bad = {bad, " glyph_ok"};
				if (got.stat.glyph_count !== want.stat.glyph_count) bad = {bad, " glyph_count"};
				if (got.stat.glyph_width !== want.stat.glyph_width) bad = {bad, " glyph_width"};
				if (got.stat.glyph_height !== want.stat.glyph_height)
					bad = {bad, " glyph_height"};
				if (got.stat.format_value !== want.stat.format_value)
					bad = {bad, " format_value"};
				if (got.stat.extra_header_word !== want.stat.extra_header_word)
					bad = {bad, " extra_header_word"};
				if (got.last_result !== want.last_result) bad = {bad, " last_result"};
				if (bad != "") begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("word %0d wrong in%s", words_checked, bad);
						$display("  expected %s", describe(want));
						$display("  actual   %s", describe(got));
					end
				end
				if (want.result_kind == fgd_pkg::RESULT_STATUS) begin
					status_words++;
					if (want.stat.glyph_ok)
						glyphs_done++;
				end else begin
					pixel_words++;
				end
			end
			words_checked++;
		end
		if ((push && !full) || (pop && !empty))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("no handshake for %0d cycles, %0d words still due", STALL_LIMIT,
				words_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned queued_bytes, n, pick;
		int phase;
		queued_bytes = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (phase = 0; phase < 6; phase++) begin
			case (phase / 2)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 51;
				end
				1: begin
					send_idle_pct = 51;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (phase)
				0: set_config($urandom, 16'd0, 21'h1FFFFF, 10'd1023);
				1: set_config(32'hFFFF_FFFF, 16'd1, 21'd200, 10'd72);
				2: set_config(32'd0, 16'd0, 21'd0, 10'd0);
				3: set_config($urandom, 16'hFFFF, 21'(MAX_BYTES), 10'd1023);
				4: set_config($urandom, 16'd0, 21'd60, 10'd144);
				default: set_config($urandom, 16'd2, 21'd250, 10'd143);
			endcase
			if (phase == 0) begin
				// lone final byte, then a header that ends right at the glyph decision
				bytes_to_send.push_back('{value: 8'hFF, last: 1'b1});
				streams_sent++;
				queue_stream(STREAM_CLEAN, fgd_pkg::P_HEIGHT + 1, n);
				queued_bytes += n + 1;
			end
			do begin
				pick = $urandom_range(9);
				if (pick < 6)
					queue_stream(STREAM_CLEAN, 0, n);
				else if (pick < 9)
					queue_stream(STREAM_BROKEN, 0, n);
				else
					queue_stream(STREAM_NOISE, 0, n);
				queued_bytes += n;
			end while (queued_bytes < (phase + 1) * PHASE_BYTES);
			while (bytes_to_send.size() != 0 || words_due.size() != 0)
				@(posedge clk);
			repeat (SETTLE) @(posedge clk);
		end
		$display("sent %0d bytes in %0d streams over 6 register settings", bytes_sent,
			streams_sent);
		$display("checked %0d pixel and %0d status words, %0d glyphs fully decoded",
			pixel_words, status_words, glyphs_done);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/fgd_pkg.sv
hw/rtl/fgd_front.sv
hw/rtl/fgd_queue.sv
hw/rtl/fgd_back.sv
hw/rtl/font_resource_glyph_decoder.sv
tb/font_resource_glyph_decoder_test.sv
